FILE: rtl/core/spss_pkg.sv
// Shared types and constants for the sorted pair sum search core.
package spss_pkg;

  // Fixed widths of the target register and the reported positions.
  localparam int TARGET_W = 32;
  localparam int POS_W    = 11;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DONE
  } search_state_e;

endpackage

FILE: rtl/core/spss_in_if.sv
// Input channel: one list value per request plus the end-of-list mark.
interface spss_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] element_value;
  logic                         last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

FILE: rtl/core/spss_out_if.sv
// Result channel: search outcome for one list.
interface spss_out_if;
  logic                       valid;
  logic                       ready;
  logic                       pair_found;
  logic [spss_pkg::POS_W-1:0] first_position;
  logic [spss_pkg::POS_W-1:0] second_position;
  logic                       list_overflow;

  modport source (output valid, output pair_found, output first_position,
                  output second_position, output list_overflow, input ready);
  modport sink   (input valid, input pair_found, input first_position,
                  input second_position, input list_overflow, output ready);
endinterface

FILE: rtl/core/spss_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module spss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/core/spss_job_queue.sv
// Two-entry queue of list descriptors between the loader and the search engine.
module spss_job_queue #(
  parameter int WIDTH = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/spss_loader.sv
// Front end: accepts list values, writes them to the store, queues a descriptor per list.
module spss_loader #(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 32,
  localparam int IDX_W = $clog2(MAX_ENTRIES),
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spss_in_if.sink               elem_i,
  input  logic                  lock_i,
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o,
  output logic [VALUE_BITS-1:0] wdata_o,
  output logic                  push_o,
  output logic [CNT_W:0]        job_o
);

  logic [CNT_W-1:0] count_q, count_d, count_nxt;
  logic             ovf_q, ovf_d, ovf_nxt;
  logic             accept;
  logic             has_room;

  assign elem_i.ready = !lock_i;
  assign accept       = elem_i.valid && elem_i.ready;
  assign has_room     = (count_q < CNT_W'(MAX_ENTRIES));
  assign waddr_o      = count_q[IDX_W-1:0];
  assign wdata_o      = elem_i.element_value;

  always_comb begin
    we_o      = 1'b0;
    push_o    = 1'b0;
    count_nxt = count_q;
    ovf_nxt   = ovf_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    if (accept) begin
      if (has_room) begin
        we_o      = 1'b1;
        count_nxt = count_q + 1'b1;
      end else begin
        // drop the value, remember it for this list
        ovf_nxt = 1'b1;
      end
      if (elem_i.last_element) begin
        push_o  = 1'b1;
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_nxt;
        ovf_d   = ovf_nxt;
      end
    end
  end

  assign job_o = {ovf_nxt, count_nxt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

FILE: rtl/core/spss_search.sv
// Back end: two-pointer search over the stored list and the result register.
module spss_search #(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 32,
  localparam int IDX_W = $clog2(MAX_ENTRIES),
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [spss_pkg::TARGET_W-1:0]  target_i,
  input  logic                                  job_valid_i,
  input  logic [CNT_W:0]                        job_i,
  output logic                                  pop_o,
  output logic [IDX_W-1:0]                      raddr_a_o,
  output logic [IDX_W-1:0]                      raddr_b_o,
  input  logic [VALUE_BITS-1:0]                 rdata_a_i,
  input  logic [VALUE_BITS-1:0]                 rdata_b_i,
  output logic                                  searching_o,
  spss_out_if.source                            result_o
);
  import spss_pkg::*;

  localparam int CMP_W = (VALUE_BITS + 1 > TARGET_W) ? VALUE_BITS + 1 : TARGET_W;

  search_state_e state_q, state_d;
  logic [IDX_W-1:0]         left_q, left_d;
  logic [IDX_W-1:0]         right_q, right_d;
  logic                     found_q, found_d;
  logic                     ovf_q, ovf_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q;
  logic [POS_W-1:0]         out_first_q, out_second_q;
  logic                     out_ovf_q;
  logic                     load_out;
  logic [CNT_W-1:0]         job_count;
  logic                     job_ovf;
  logic signed [VALUE_BITS-1:0] val_a, val_b;
  logic signed [CMP_W-1:0]  pair_sum, target_ext;
  logic [IDX_W:0]           left_pos, right_pos;

  assign job_count  = job_i[CNT_W-1:0];
  assign job_ovf    = job_i[CNT_W];
  assign val_a      = rdata_a_i;
  assign val_b      = rdata_b_i;
  assign pair_sum   = CMP_W'(val_a) + CMP_W'(val_b);
  assign target_ext = CMP_W'(target_i);
  assign left_pos   = {1'b0, left_q} + 1'b1;
  assign right_pos  = {1'b0, right_q} + 1'b1;

  assign raddr_a_o   = left_d;
  assign raddr_b_o   = right_d;
  assign searching_o = (state_q == S_STEP);

  always_comb begin
    state_d  = state_q;
    left_d   = left_q;
    right_d  = right_q;
    found_d  = found_q;
    ovf_d    = ovf_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        left_d  = '0;
        right_d = IDX_W'(job_count - 1'b1);
        if (job_valid_i) begin
          pop_o   = 1'b1;
          found_d = 1'b0;
          ovf_d   = job_ovf;
          // a single stored entry leaves nothing to pair
          state_d = (job_count == CNT_W'(1)) ? S_DONE : S_STEP;
        end
      end
      S_STEP: begin
        if (pair_sum == target_ext) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else begin
          if (pair_sum > target_ext) begin
            right_d = right_q - 1'b1;
          end else begin
            left_d = left_q + 1'b1;
          end
          if (left_d == right_d) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        // hold the outcome until the result register frees up
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      left_q      <= '0;
      right_q     <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      right_q     <= right_d;
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q  <= found_q;
      out_first_q  <= found_q ? POS_W'(left_pos) : '0;
      out_second_q <= found_q ? POS_W'(right_pos) : '0;
      out_ovf_q    <= ovf_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.pair_found      = out_found_q;
  assign result_o.first_position  = out_first_q;
  assign result_o.second_position = out_second_q;
  assign result_o.list_overflow   = out_ovf_q;

`ifndef SYNTHESIS
  a_step_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEP |-> left_q < right_q)
    else $error("search pointers crossed while stepping");

  a_miss_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_first_q == '0 && out_second_q == '0)
    else $error("positions nonzero on a miss");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("finished search did not reach the result register");
`endif

endmodule

FILE: rtl/core/sorted_pair_sum_search_core.sv
// Sorted pair sum search: values stream into a store, one per request and one per cycle
// while not stalled; a request with last_element set closes the list and starts a
// two-pointer search for two entries summing to the target register. The search moves one
// pointer per step (at most stored entries minus one steps, each reading both pointers
// from the two store read ports), then hands off the result. Input requests stall while
// a list waits or a search reads the store; a finished result waits in an output register
// while the next list loads. The store needs no clearing after reset. Values beyond
// MAX_ENTRIES are dropped and flagged in list_overflow.
module sorted_pair_sum_search_core #(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spss_pkg::TARGET_W-1:0] cfg_wdata_i,
  spss_in_if.sink                       elem_i,
  spss_out_if.source                    result_o
);
  import spss_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic signed [TARGET_W-1:0] target_q;
  logic                       we;
  logic [IDX_W-1:0]           waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0]      wdata, rdata_a, rdata_b;
  logic                       push, pop, job_full, job_valid, searching;
  logic [CNT_W:0]             job_in, job_out;
  logic                       lock;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // hold new values off the store while a list waits or is being searched
  assign lock = job_full || job_valid || searching;

  spss_loader #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_loader (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .elem_i  (elem_i),
    .lock_i  (lock),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .push_o  (push),
    .job_o   (job_in)
  );

  spss_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  spss_job_queue #(
    .WIDTH (CNT_W + 1)
  ) u_jobs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  spss_search #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .target_i    (target_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .searching_o (searching),
    .result_o    (result_o)
  );

endmodule
